>>> hdl/mcg_pkg.sv
// Shared constants, types and state codes for the metronome click generator.
`timescale 1ns / 1ps

package mcg_pkg;

    // Sine resolution and count-in length.
    localparam int SINE_TABLE_BITS = 10;
    localparam int COUNT_IN_BEATS  = 4;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int SINE_X_SHIFT    = 18 - SINE_TABLE_BITS;

    // Field and state widths.
    localparam int PHASE_W = 24;
    localparam int COUNT_W = 23;
    localparam int BEAT_W  = 16;
    localparam int LEN_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int SPB_W   = 20;
    localparam int BPB_W   = 5;
    localparam int POS_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W   = SAMPLE_W + 1;

    // Shared multiplier and divider widths.
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DEN_W  = 2 * LEN_W;
    localparam int NUM_W  = 2 * LEN_W + 16;
    localparam int QUO_W  = 17;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MUL_W-1:0] AMP_DOWN = 17'd16384;
    localparam logic [MUL_W-1:0] AMP_UP   = 17'd10486;
    localparam logic [MUL_W-1:0] SINE_C1  = 17'd4640;
    localparam logic [MUL_W-1:0] SINE_C2  = 17'd42047;
    localparam logic [MUL_W-1:0] SINE_C3  = 17'd102944;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPB       = 3'd0,
        REG_BPB       = 3'd1,
        REG_MET_EN    = 3'd2,
        REG_GAIN      = 3'd3,
        REG_DOWN_LEN  = 3'd4,
        REG_UP_LEN    = 3'd5,
        REG_DOWN_STEP = 3'd6,
        REG_UP_STEP   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SPB_W-1:0]   spb;
        logic [BPB_W-1:0]   bpb;
        logic               met_en;
        logic [GAIN_W-1:0]  gain;
        logic [LEN_W-1:0]   down_len;
        logic [LEN_W-1:0]   up_len;
        logic [PHASE_W-1:0] down_step;
        logic [PHASE_W-1:0] up_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        spb:       20'd24000,
        bpb:       5'd4,
        met_en:    1'b0,
        gain:      16'd32768,
        down_len:  16'd2880,
        up_len:    16'd1920,
        down_step: 24'd548056,
        up_step:   24'd365780
    };

    typedef struct packed {
        logic [1:0]       func;
        logic [POS_W-1:0] beat_position;
        logic             playing;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] click_sample;
        logic                       count_in_done;
        logic                       counting_in;
    } res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CNT,
        ST_CNT_END,
        ST_MET,
        ST_MET_HIT,
        ST_MOD,
        ST_R_CHK,
        ST_R_RR,
        ST_R_LL,
        ST_R_DIV,
        ST_R_DIVW,
        ST_R_X2,
        ST_R_P1,
        ST_R_P2,
        ST_R_P3,
        ST_R_Y,
        ST_R_ACC,
        ST_OUT
    } state_t;

endpackage

>>> hdl/mcg_mul.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module mcg_mul
    import mcg_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

>>> hdl/mcg_div.sv
// Restoring divider producing one quotient bit per cycle, with remainder.
`timescale 1ns / 1ps

module mcg_div
    import mcg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic [NUM_W-1:0] rem
);

    // The quotient is known to fit in QUO_W bits, so the divisor starts
    // shifted up by QUO_W-1 places and walks down one place per cycle.
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     den_sh_reg, den_sh_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        quo_next    = quo_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = DIV_CNT_W'(QUO_W);
            rem_next    = num;
            den_sh_next = NUM_W'(den) << (QUO_W - 1);
            quo_next    = '0;
        end else if (busy_reg) begin
            if (rem_reg >= den_sh_reg) begin
                rem_next = rem_reg - den_sh_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            den_sh_next = den_sh_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        quo_reg    <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/mcg_core.sv
// Sequencer holding count-in, metronome and click state around the shared units.
`timescale 1ns / 1ps

module mcg_core
    import mcg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       start,
    input  item_t      item,
    input  logic       res_take,
    output core_stat_t stat,
    output res_t       res
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    logic [COUNT_W-1:0]  count_left_reg, count_left_next;
    logic [COUNT_W-1:0]  count_total_reg, count_total_next;
    logic [COUNT_W-1:0]  count_nb_reg, count_nb_next;
    logic [BEAT_W-1:0]   metro_reg, metro_next;
    logic [LEN_W-1:0]    click_rem_reg, click_rem_next;
    logic [LEN_W-1:0]    click_len_reg, click_len_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PHASE_W-1:0]  step_reg, step_next;
    logic                is_down_reg, is_down_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                done_reg, done_next;

    // Working registers of one item.
    logic [POS_W-1:0]    bp_reg, bp_next;
    logic                playing_reg, playing_next;
    logic [GAIN_W-1:0]   m_reg, m_next;
    logic [DEN_W-1:0]    rem2_reg, rem2_next;
    logic [GAIN_W-1:0]   m2_reg, m2_next;
    logic [MUL_W-1:0]    x_reg, x_next;
    logic [MUL_W-1:0]    x2_reg, x2_next;
    logic                neg_reg, neg_next;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic                div_start, div_busy, div_done;
    logic [NUM_W-1:0]    div_num, div_rem;
    logic [DEN_W-1:0]    div_den;
    logic [QUO_W-1:0]    div_quo;

    logic                click_load, click_down;

    logic [SPB_W-1:0]    spb_eff;
    logic [BPB_W-1:0]    bpb_eff;
    logic [SPB_W+4:0]    cin_total;
    logic [COUNT_W:0]    cnb_sum;
    logic [COUNT_W-1:0]  elapsed;
    logic [POS_W-1:0]    metro_pos;
    logic [POS_W:0]      bp_hi;
    logic [POS_W:0]      bp_ceil;

    logic [SINE_TABLE_BITS-1:0] sine_idx;
    logic [1:0]                 sine_q;
    logic [QUARTER_BITS:0]      sine_r;
    logic [MUL_W:0]             y_round;
    logic [MUL_W-1:0]           s_mag;
    logic signed [ACC_W-1:0]    mag_s;

    mcg_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mcg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign spb_eff   = (cfg.spb == '0) ? SPB_W'(1) : cfg.spb;
    assign bpb_eff   = (cfg.bpb == '0) ? BPB_W'(1) : cfg.bpb;
    assign cin_total = (SPB_W+5)'(spb_eff) * (SPB_W+5)'(COUNT_IN_BEATS);
    assign cnb_sum   = (COUNT_W+1)'(count_nb_reg) + (COUNT_W+1)'(spb_eff);
    assign elapsed   = count_total_reg - count_left_reg;
    assign metro_pos = {metro_reg, 16'h0000};
    assign bp_hi     = (POS_W+1)'(bp_reg) + (POS_W+1)'(32'h0001_8000);
    assign bp_ceil   = (POS_W+1)'(bp_reg) + (POS_W+1)'(32'h0000_FFFF);

    // Quarter-wave mapping: mirror the fraction in the odd quarters.
    assign sine_idx = phase_reg[PHASE_W-1 -: SINE_TABLE_BITS];
    assign sine_q   = sine_idx[SINE_TABLE_BITS-1 -: 2];
    assign sine_r   = sine_q[0]
                    ? ({1'b1, {QUARTER_BITS{1'b0}}} - {1'b0, sine_idx[QUARTER_BITS-1:0]})
                    : {1'b0, sine_idx[QUARTER_BITS-1:0]};

    assign y_round = ((MUL_W+1)'(prod[PROD_W-1:16]) + (MUL_W+1)'(1)) >> 1;
    assign s_mag   = (y_round > (MUL_W+1)'(32767)) ? MUL_W'(32767) : y_round[MUL_W-1:0];
    assign mag_s   = $signed({1'b0, prod[30:15]});

    always_comb begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        count_left_next  = count_left_reg;
        count_total_next = count_total_reg;
        count_nb_next    = count_nb_reg;
        metro_next       = metro_reg;
        click_rem_next   = click_rem_reg;
        click_len_next   = click_len_reg;
        phase_next       = phase_reg;
        step_next        = step_reg;
        is_down_next     = is_down_reg;
        acc_next         = acc_reg;
        done_next        = done_reg;
        bp_next          = bp_reg;
        playing_next     = playing_reg;
        m_next           = m_reg;
        rem2_next        = rem2_reg;
        m2_next          = m2_reg;
        x_next           = x_reg;
        x2_next          = x2_reg;
        neg_next         = neg_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;
        div_num          = {rem2_reg, 16'h0000};
        div_den          = prod[DEN_W-1:0];
        click_load       = 1'b0;
        click_down       = 1'b0;
        stat.idle        = 1'b0;
        stat.res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    acc_next     = '0;
                    done_next    = 1'b0;
                    bp_next      = item.beat_position;
                    playing_next = item.playing;
                    case (func_t'(item.func))
                        FUNC_START: begin
                            if (cin_total > (SPB_W+5)'(COUNT_MAX)) begin
                                count_total_next = COUNT_MAX;
                                count_left_next  = COUNT_MAX;
                            end else begin
                                count_total_next = cin_total[COUNT_W-1:0];
                                count_left_next  = cin_total[COUNT_W-1:0];
                            end
                            count_nb_next = '0;
                            state_next    = ST_OUT;
                        end
                        FUNC_CANCEL: begin
                            count_left_next = '0;
                            state_next      = ST_OUT;
                        end
                        FUNC_TICK: begin
                            state_next = ST_CNT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_CNT: begin
                if (count_left_reg != '0) begin
                    if (elapsed >= count_nb_reg) begin
                        click_load = 1'b1;
                        click_down = (count_nb_reg == '0);
                        count_nb_next = cnb_sum[COUNT_W] ? COUNT_MAX : cnb_sum[COUNT_W-1:0];
                    end
                    pass_next  = 1'b0;
                    state_next = ST_R_CHK;
                end else begin
                    state_next = ST_MET;
                end
            end

            ST_CNT_END: begin
                count_left_next = count_left_reg - 1'b1;
                if (count_left_reg == COUNT_W'(1)) begin
                    done_next      = 1'b1;
                    click_rem_next = '0;
                end
                state_next = ST_MET;
            end

            ST_MET: begin
                if (cfg.met_en && playing_reg) begin
                    pass_next = 1'b1;
                    if (bp_reg <= 32'hFFFF_0000) begin
                        if (metro_pos < bp_reg || (POS_W+1)'(metro_pos) > bp_hi) begin
                            metro_next = bp_ceil[POS_W-1:16];
                        end
                        state_next = ST_MET_HIT;
                    end else begin
                        state_next = ST_R_CHK;
                    end
                end else begin
                    if (count_left_reg == '0) begin
                        click_rem_next = '0;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_MET_HIT: begin
                if (bp_reg >= metro_pos) begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'(metro_reg);
                    div_den    = DEN_W'(bpb_eff);
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_R_CHK;
                end
            end

            ST_MOD: begin
                if (div_done) begin
                    click_load = 1'b1;
                    click_down = (div_rem == '0);
                    metro_next = metro_reg + 1'b1;
                    state_next = ST_R_CHK;
                end
            end

            ST_R_CHK: begin
                if (click_rem_reg == '0 || click_len_reg == '0) begin
                    state_next = pass_reg ? ST_OUT : ST_CNT_END;
                end else begin
                    mul_a      = MUL_W'(cfg.gain);
                    mul_b      = is_down_reg ? AMP_DOWN : AMP_UP;
                    state_next = ST_R_RR;
                end
            end

            ST_R_RR: begin
                m_next     = prod[30:15];
                mul_a      = MUL_W'(click_rem_reg);
                mul_b      = MUL_W'(click_rem_reg);
                state_next = ST_R_LL;
            end

            ST_R_LL: begin
                rem2_next  = prod[DEN_W-1:0];
                mul_a      = MUL_W'(click_len_reg);
                mul_b      = MUL_W'(click_len_reg);
                state_next = ST_R_DIV;
            end

            ST_R_DIV: begin
                div_start  = 1'b1;
                state_next = ST_R_DIVW;
            end

            ST_R_DIVW: begin
                if (div_done) begin
                    mul_a      = MUL_W'(m_reg);
                    mul_b      = div_quo;
                    state_next = ST_R_X2;
                end
            end

            ST_R_X2: begin
                m2_next    = prod[31:16];
                x_next     = MUL_W'(sine_r) << SINE_X_SHIFT;
                neg_next   = sine_q[1];
                mul_a      = MUL_W'(sine_r) << SINE_X_SHIFT;
                mul_b      = MUL_W'(sine_r) << SINE_X_SHIFT;
                state_next = ST_R_P1;
            end

            ST_R_P1: begin
                x2_next    = prod[32:16];
                mul_a      = SINE_C1;
                mul_b      = prod[32:16];
                state_next = ST_R_P2;
            end

            ST_R_P2: begin
                mul_a      = SINE_C2 - prod[32:16];
                mul_b      = x2_reg;
                state_next = ST_R_P3;
            end

            ST_R_P3: begin
                mul_a      = SINE_C3 - prod[32:16];
                mul_b      = x_reg;
                state_next = ST_R_Y;
            end

            ST_R_Y: begin
                mul_a      = MUL_W'(m2_reg);
                mul_b      = s_mag;
                state_next = ST_R_ACC;
            end

            ST_R_ACC: begin
                acc_next       = neg_reg ? (acc_reg - mag_s) : (acc_reg + mag_s);
                phase_next     = phase_reg + step_reg;
                click_rem_next = click_rem_reg - 1'b1;
                state_next     = pass_reg ? ST_OUT : ST_CNT_END;
            end

            ST_OUT: begin
                stat.res_valid = 1'b1;
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (click_load) begin
            click_len_next = click_down ? cfg.down_len : cfg.up_len;
            click_rem_next = click_down ? cfg.down_len : cfg.up_len;
            phase_next     = '0;
            step_next      = click_down ? cfg.down_step : cfg.up_step;
            is_down_next   = click_down;
        end
    end

    always_comb begin
        if (acc_reg > ACC_W'(32767)) begin
            res.click_sample = 16'sh7FFF;
        end else if (acc_reg < -ACC_W'(32768)) begin
            res.click_sample = 16'sh8000;
        end else begin
            res.click_sample = acc_reg[SAMPLE_W-1:0];
        end
        res.count_in_done = done_reg;
        res.counting_in   = (count_left_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pass_reg        <= 1'b0;
            count_left_reg  <= '0;
            count_total_reg <= '0;
            count_nb_reg    <= '0;
            metro_reg       <= '0;
            click_rem_reg   <= '0;
            click_len_reg   <= '0;
            phase_reg       <= '0;
            step_reg        <= '0;
            is_down_reg     <= 1'b0;
            acc_reg         <= '0;
            done_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pass_reg        <= pass_next;
            count_left_reg  <= count_left_next;
            count_total_reg <= count_total_next;
            count_nb_reg    <= count_nb_next;
            metro_reg       <= metro_next;
            click_rem_reg   <= click_rem_next;
            click_len_reg   <= click_len_next;
            phase_reg       <= phase_next;
            step_reg        <= step_next;
            is_down_reg     <= is_down_next;
            acc_reg         <= acc_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        bp_reg      <= bp_next;
        playing_reg <= playing_next;
        m_reg       <= m_next;
        rem2_reg    <= rem2_next;
        m2_reg      <= m2_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        neg_reg     <= neg_next;
    end

    // The envelope division relies on the remaining length never exceeding
    // the click length, which keeps the quotient inside the divider width.
    a_rem_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        click_rem_reg <= click_len_reg)
        else $error("click remaining exceeds click length");

    a_left_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        count_left_reg <= count_total_reg)
        else $error("count-in remaining exceeds its total");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_cin_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CNT_END && count_left_reg == COUNT_W'(1))
        |=> (click_rem_reg == '0 && done_reg && count_left_reg == '0))
        else $error("count-in end did not silence the click");

endmodule

>>> hdl/metronome_click_generator.sv
// Top level of the metronome and count-in click generator.
`timescale 1ns / 1ps

// The block produces one click sample per audio-sample transaction on the
// s_ channel and returns exactly one result transaction on the m_ channel for
// every input. A tick (func 0) renders the count-in click and then the
// metronome click; a start (func 1) arms a count-in and a cancel (func 2)
// stops it, both returning a silent sample.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata, one register per cycle, and must only be changed while the block
// is idle.
// A non-tick transaction goes straight to the output state, and s_ready returns
// in the same cycle that its result enters the output register. A tick steps
// through its bookkeeping states and, for each click that is rendered, waits
// on the envelope division and makes nine passes through the shared
// multiplier; when the metronome starts a new beat it also waits on the
// divider, since the bar position uses the same divider. s_ready is high only
// while idle, so a new tick is taken only once the previous one is through.
// The result sits in an output register, so a new input can be accepted while
// a previous result still waits for m_ready; if the receiver stalls for longer,
// the sequencer holds its result. A synchronous reset clears all beat state.

module metronome_click_generator
    import mcg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [POS_W-1:0]           s_beat_position,
    input  logic                       s_transport_playing,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_click_sample,
    output logic                       m_count_in_done,
    output logic                       m_counting_in
);

    cfg_t       cfg_reg, cfg_next;
    core_stat_t stat;
    res_t       res;
    item_t      item;
    logic       core_start;
    logic       res_take;

    logic       m_valid_reg, m_valid_next;
    res_t       m_res_reg, m_res_next;

    // Register file: each write replaces one field, masked to its width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SPB:       cfg_next.spb       = cfg_wdata[SPB_W-1:0];
                REG_BPB:       cfg_next.bpb       = cfg_wdata[BPB_W-1:0];
                REG_MET_EN:    cfg_next.met_en    = cfg_wdata[0];
                REG_GAIN:      cfg_next.gain      = cfg_wdata[GAIN_W-1:0];
                REG_DOWN_LEN:  cfg_next.down_len  = cfg_wdata[LEN_W-1:0];
                REG_UP_LEN:    cfg_next.up_len    = cfg_wdata[LEN_W-1:0];
                REG_DOWN_STEP: cfg_next.down_step = cfg_wdata[PHASE_W-1:0];
                REG_UP_STEP:   cfg_next.up_step   = cfg_wdata[PHASE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    assign s_ready    = stat.idle;
    assign core_start = s_valid && stat.idle;

    assign item = '{func: s_func, beat_position: s_beat_position,
                    playing: s_transport_playing};

    // The sequencer hands its result over once the output register is free.
    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (stat.res_valid && res_take) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    mcg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .start    (core_start),
        .item     (item),
        .res_take (res_take),
        .stat     (stat),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_click_sample  = m_res_reg.click_sample;
    assign m_count_in_done = m_res_reg.count_in_done;
    assign m_counting_in   = m_res_reg.counting_in;

endmodule
